/* rtl/cfir_pkg.sv */
// Shared constants, types and register codes of the centred FIR with missing data.
// No dependencies; imported by cfir_mac and centered_fir_with_missing_data.
package cfir_pkg;

  localparam int DATA_WIDTH     = 16;
  localparam int COEF_WIDTH     = 16;
  localparam int COEF_FRAC_BITS = 14;
  localparam int MAX_TAPS       = 7;
  localparam int SUM_TOLERANCE  = 1;
  localparam int TAP_W          = 3;
  localparam int CNT_W          = 3;
  localparam int ADDR_W         = 5;
  localparam int PDATA_W        = 32;
  localparam int ACC_W          = DATA_WIDTH + COEF_WIDTH + $clog2(MAX_TAPS);
  localparam int CSUM_W         = COEF_WIDTH + $clog2(MAX_TAPS);

  typedef logic signed [DATA_WIDTH-1:0] sample_t;
  typedef logic signed [COEF_WIDTH-1:0] coef_t;
  typedef logic [TAP_W-1:0]             tap_t;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_TAP_COUNT = 3'd0;
  localparam logic [2:0] REG_COEF_0    = 3'd1;

  // Reset values
  localparam tap_t  TAP_RESET  = TAP_W'(1);
  localparam coef_t COEF_ONE   = COEF_WIDTH'(1 << COEF_FRAC_BITS);

  // Dot product result handed from the MAC to the result stage
  typedef struct packed {
    logic    ok;
    sample_t value;
  } mac_res_t;

endpackage

/* rtl/cfir_mac.sv */
// Weighted sum of the centred window: seven parallel multiplies, adder, round, saturate.
// Also checks tap count, coefficient sum and sample availability. Uses cfir_pkg.
module cfir_mac
  import cfir_pkg::*;
(
  input  tap_t     tap_count,
  input  coef_t    coefs      [MAX_TAPS],
  input  sample_t  win_values [MAX_TAPS],
  input  logic     win_flags  [MAX_TAPS],
  output mac_res_t res
);

  localparam logic signed [CSUM_W-1:0] SUM_LO =
    CSUM_W'((1 << COEF_FRAC_BITS) - SUM_TOLERANCE);
  localparam logic signed [CSUM_W-1:0] SUM_HI =
    CSUM_W'((1 << COEF_FRAC_BITS) + SUM_TOLERANCE);
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1 << (COEF_FRAC_BITS - 1));
  localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'((1 << (DATA_WIDTH - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO   = -SAT_HI - ACC_W'(1);

  logic signed [ACC_W-1:0]  prod [MAX_TAPS];
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [CSUM_W-1:0] csum;
  logic [TAP_W-1:0]         idx  [MAX_TAPS];
  logic                     flags_ok;
  logic                     taps_ok;
  logic                     sum_ok;

  // Pick the window sample for each coefficient: coef 0 weights the oldest in use
  always_comb begin
    for (int c = 0; c < MAX_TAPS; c++) begin
      idx[c] = tap_count - TAP_W'(c) - TAP_W'(1);
    end
  end

  // Multiply every tap in use, gate the others to zero
  always_comb begin
    flags_ok = 1'b1;
    for (int c = 0; c < MAX_TAPS; c++) begin
      if (TAP_W'(c) < tap_count) begin
        prod[c] = ACC_W'(win_values[idx[c]] * coefs[c]);
        if (!win_flags[idx[c]]) begin
          flags_ok = 1'b0;
        end
      end else begin
        prod[c] = '0;
      end
    end
  end

  // Sum products and used coefficients
  always_comb begin
    acc  = '0;
    csum = '0;
    for (int c = 0; c < MAX_TAPS; c++) begin
      acc = acc + prod[c];
      if (TAP_W'(c) < tap_count) begin
        csum = csum + CSUM_W'(coefs[c]);
      end
    end
  end

  assign taps_ok = tap_count[0] && (32'(tap_count) <= MAX_TAPS);
  assign sum_ok  = (csum >= SUM_LO) && (csum <= SUM_HI);

  // Round to nearest (ties upward), then saturate
  assign rnd = (acc + RND_HALF) >>> COEF_FRAC_BITS;

  always_comb begin
    res.ok = taps_ok && sum_ok && flags_ok;
    if (!res.ok) begin
      res.value = '0;
    end else if (rnd > SAT_HI) begin
      res.value = SAT_HI[DATA_WIDTH-1:0];
    end else if (rnd < SAT_LO) begin
      res.value = SAT_LO[DATA_WIDTH-1:0];
    end else begin
      res.value = rnd[DATA_WIDTH-1:0];
    end
  end

endmodule

/* rtl/centered_fir_with_missing_data.sv */
// Top level of the centred FIR with missing data: config registers, delay line, result stage.
// Uses cfir_pkg and cfir_mac.
// An accepted item is held in the input stage register and then loaded into the result register,
// from which its first result word is offered.
// Throughput: one item per cycle while out_stall is low and each item gives at most one word;
// end-of-series items give up to four words, one per cycle, set by the single result register.
// Reset (synchronous, rst_n low) empties both stages, clears the window flags and position
// count, and sets tap_count to 1 and coef_0 to 1.0 with the other weights zero.
module centered_fir_with_missing_data
  import cfir_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input words
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sample_t               in_sample,
  input  logic                  in_sample_valid,
  input  logic                  in_end_of_series,
  // result words
  output logic                  out_valid,
  input  logic                  out_stall,
  output sample_t               out_filtered,
  output logic                  out_filtered_valid,
  output logic                  out_last_result,
  // configuration
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [ADDR_W-1:0]     cfg_paddr,
  input  logic [PDATA_W-1:0]    cfg_pwdata,
  output logic [PDATA_W-1:0]    cfg_prdata,
  output logic                  cfg_pready
);

  // Configuration registers
  tap_t              tap_r;
  coef_t             coef_r [MAX_TAPS];
  logic [2:0]        reg_idx;
  logic              cfg_wr;

  // Input stage: delay line holds the window of the item in this stage
  sample_t           win_val_r [MAX_TAPS];
  logic              win_flg_r [MAX_TAPS];
  logic [CNT_W-1:0]  cnt_r;
  logic              flush_r;
  logic              a_valid_r;
  logic [CNT_W-1:0]  a_pos_r;
  logic              a_end_r;

  // Result stage
  logic              b_valid_r;
  sample_t           b_val_r;
  logic              b_ok_r;
  logic [2:0]        b_total_r;
  logic              b_end_r;
  logic [1:0]        b_k_r;

  logic              in_accept;
  logic              out_accept;
  logic [1:0]        half_taps;
  logic [2:0]        edge_cnt;
  logic [2:0]        a_total;
  logic              a_centred;
  logic              a_move;
  logic              b_load;
  logic              b_last_k;
  logic              b_done;
  logic              b_free;
  mac_res_t          mac_res;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r <= TAP_RESET;
      for (int j = 0; j < MAX_TAPS; j++) begin
        coef_r[j] <= (j == 0) ? COEF_ONE : '0;
      end
    end else if (cfg_wr) begin
      if (reg_idx == REG_TAP_COUNT) begin
        tap_r <= cfg_pwdata[TAP_W-1:0];
      end else begin
        coef_r[reg_idx - REG_COEF_0] <= cfg_pwdata[COEF_WIDTH-1:0];
      end
    end
  end

  always_comb begin
    if (reg_idx == REG_TAP_COUNT) begin
      cfg_prdata = PDATA_W'(tap_r);
    end else begin
      cfg_prdata = PDATA_W'(coef_r[reg_idx - REG_COEF_0]);
    end
  end

  // Word counts for the item in the input stage
  assign half_taps = tap_r[2:1];
  assign edge_cnt  = (a_pos_r < CNT_W'(half_taps)) ? a_pos_r : CNT_W'(half_taps);
  assign a_total   = a_end_r ? (edge_cnt + 3'd1)
                             : ((a_pos_r >= CNT_W'(half_taps)) ? 3'd1 : 3'd0);
  assign a_centred = (a_pos_r >= {half_taps, 1'b0});

  // Handshake and stage movement
  assign out_accept = b_valid_r && !out_stall;
  assign b_last_k   = ({1'b0, b_k_r} == (b_total_r - 3'd1));
  assign b_done     = out_accept && b_last_k;
  assign b_free     = !b_valid_r || b_done;
  assign a_move     = a_valid_r && ((a_total == 3'd0) || b_free);
  assign b_load     = a_move && (a_total != 3'd0);
  assign in_stall   = a_valid_r && !a_move;
  assign in_accept  = in_valid && !in_stall;

  // Advance the delay line and position count on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      cnt_r     <= '0;
      flush_r   <= 1'b0;
      for (int j = 0; j < MAX_TAPS; j++) begin
        win_flg_r[j] <= 1'b0;
      end
    end else if (in_accept) begin
      a_valid_r    <= 1'b1;
      a_pos_r      <= cnt_r;
      a_end_r      <= in_end_of_series;
      flush_r      <= in_end_of_series;
      win_val_r[0] <= in_sample;
      win_flg_r[0] <= in_sample_valid;
      for (int j = 1; j < MAX_TAPS; j++) begin
        win_val_r[j] <= win_val_r[j-1];
        win_flg_r[j] <= win_flg_r[j-1] && !flush_r;
      end
      if (in_end_of_series) begin
        cnt_r <= '0;
      end else if (cnt_r != '1) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end else if (a_move) begin
      a_valid_r <= 1'b0;
    end
  end

  // The window seen by the MAC still carries flags of a finished series until shifted;
  // the item in the input stage owns exactly this window.
  cfir_mac u_mac (
    .tap_count  (tap_r),
    .coefs      (coef_r),
    .win_values (win_val_r),
    .win_flags  (win_flg_r),
    .res        (mac_res)
  );

  // Result stage: hold the centred result, then step through the edge words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      b_k_r     <= '0;
    end else if (b_load) begin
      b_valid_r <= 1'b1;
      b_k_r     <= '0;
      b_total_r <= a_total;
      b_end_r   <= a_end_r;
      b_ok_r    <= a_centred && mac_res.ok;
      b_val_r   <= a_centred ? mac_res.value : '0;
    end else if (b_done) begin
      b_valid_r <= 1'b0;
    end else if (out_accept) begin
      b_k_r <= b_k_r + 2'd1;
    end
  end

  // Only the first word of an item can carry a value
  assign out_valid          = b_valid_r;
  assign out_filtered       = (b_k_r == 2'd0) ? b_val_r : '0;
  assign out_filtered_valid = (b_k_r == 2'd0) && b_ok_r;
  assign out_last_result    = b_end_r && b_last_k;

endmodule
